>>> sv/ipi_message_queues_macros.svh
`ifndef IPI_MESSAGE_QUEUES_MACROS_SVH
`define IPI_MESSAGE_QUEUES_MACROS_SVH

// Concurrent check sampled on the rising clock, switched off while reset is held.
`define IPIMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Concurrent check that stays live during reset.
`define IPIMQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

>>> sv/ipimq_pkg.sv
`default_nettype none

package ipimq_pkg;

  localparam int unsigned NumCpusDef     = 8;
  localparam int unsigned QueueDepthDef  = 32;
  localparam int unsigned PayloadBitsDef = 32;

  localparam logic [3:0] ActiveCpusRst = 4'd8;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_CPU,
    ST_FULL,
    ST_EMPTY
  } status_e;

  // Decision of the queue stage, handed to the result stage.
  typedef struct packed {
    logic       valid;
    status_e    status;
    logic       got;
    logic [2:0] cpu;
    logic [5:0] level;
  } stage_t;

endpackage

`default_nettype wire

>>> sv/ipimq_msg_ram.sv
`default_nettype none

module ipimq_msg_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 38
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/ipimq_queue_ctrl.sv
`default_nettype none

module ipimq_queue_ctrl import ipimq_pkg::*; #(
  parameter int unsigned CPU_COUNT    = NumCpusDef,
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic        req_type_i,
  input  wire logic [2:0]  src_cpu_i,
  input  wire logic [2:0]  target_cpu_i,
  input  wire logic [2:0]  msg_type_i,
  input  wire logic [31:0] payload_i,
  input  wire logic [3:0]  active_cpus_i,
  output logic             mem_en_o,
  output logic             mem_we_o,
  output logic [$clog2(CPU_COUNT*QUEUE_DEPTH)-1:0] mem_addr_o,
  output logic [6+((PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32)-1:0] mem_wdata_o,
  output stage_t           stage_o
);

  localparam int unsigned CpuW      = $clog2(CPU_COUNT);
  localparam int unsigned PtrW      = $clog2(QUEUE_DEPTH);
  localparam int unsigned LvlW      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AddrW     = $clog2(CPU_COUNT * QUEUE_DEPTH);
  localparam int unsigned StoreBits = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  localparam logic [4:0]      NumCpusLim = 5'(CPU_COUNT);
  localparam logic [LvlW-1:0] FullLevel  = LvlW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastSlot   = PtrW'(QUEUE_DEPTH - 1);

  logic [PtrW-1:0] rd_ptr_q [CPU_COUNT];
  logic [PtrW-1:0] wr_ptr_q [CPU_COUNT];
  logic [LvlW-1:0] fill_q   [CPU_COUNT];
  stage_t          stage_q;

  logic [CpuW-1:0] idx;
  logic [4:0]      limit;
  logic            target_ok;
  logic [LvlW-1:0] fill_cur;
  logic [LvlW-1:0] level_after;
  logic            is_send;
  logic            is_take;
  logic            full;
  logic            empty;
  logic            send_ok;
  logic            take_ok;
  logic [PtrW-1:0] ptr;
  logic [PtrW-1:0] ptr_next;
  status_e         status;
  stage_t          stage_d;

  always_comb begin
    idx       = CpuW'(target_cpu_i);
    limit     = ({1'b0, active_cpus_i} < NumCpusLim) ? {1'b0, active_cpus_i} : NumCpusLim;
    target_ok = {2'b00, target_cpu_i} < limit;
    fill_cur  = fill_q[idx];
    is_send   = req_type_i == REQ_SEND;
    is_take   = req_type_i == REQ_TAKE;
    full      = fill_cur == FullLevel;
    empty     = fill_cur == '0;
    send_ok   = accept_i && target_ok && is_send && !full;
    take_ok   = accept_i && target_ok && is_take && !empty;
    ptr       = is_send ? wr_ptr_q[idx] : rd_ptr_q[idx];
    ptr_next  = (ptr == LastSlot) ? '0 : ptr + 1'b1;

    if (!target_ok) begin
      status = ST_BAD_CPU;
    end else if (is_send && full) begin
      status = ST_FULL;
    end else if (is_take && empty) begin
      status = ST_EMPTY;
    end else begin
      status = ST_OK;
    end

    if (!target_ok) begin
      level_after = '0;
    end else if (send_ok) begin
      level_after = fill_cur + 1'b1;
    end else if (take_ok) begin
      level_after = fill_cur - 1'b1;
    end else begin
      level_after = fill_cur;
    end

    stage_d.valid  = accept_i;
    stage_d.status = status;
    stage_d.got    = take_ok;
    stage_d.cpu    = target_cpu_i;
    stage_d.level  = 6'(level_after);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CPU_COUNT; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        fill_q[i]   <= '0;
      end
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
      if (send_ok) begin
        wr_ptr_q[idx] <= ptr_next;
        fill_q[idx]   <= fill_cur + 1'b1;
      end
      if (take_ok) begin
        rd_ptr_q[idx] <= ptr_next;
        fill_q[idx]   <= fill_cur - 1'b1;
      end
    end
  end

  assign mem_en_o    = send_ok || take_ok;
  assign mem_we_o    = send_ok;
  assign mem_addr_o  = AddrW'(idx) * AddrW'(QUEUE_DEPTH) + AddrW'(ptr);
  assign mem_wdata_o = {src_cpu_i, msg_type_i, payload_i[StoreBits-1:0]};
  assign stage_o     = stage_q;

endmodule

`default_nettype wire

>>> sv/ipimq_result.sv
`default_nettype none

module ipimq_result import ipimq_pkg::*; #(
  parameter int unsigned CPU_COUNT    = NumCpusDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire stage_t      stage_i,
  input  wire logic [6+((PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32)-1:0] rdata_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic             got_message_o,
  output logic [2:0]       out_src_cpu_o,
  output logic [2:0]       out_msg_type_o,
  output logic [31:0]      out_payload_o,
  output logic             type_known_o,
  output logic [1:0]       cpu_state_now_o,
  output logic [5:0]       queue_level_o
);

  localparam int unsigned CpuW      = $clog2(CPU_COUNT);
  localparam int unsigned StoreBits = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

  localparam logic [2:0] IPI_RESCHED = 3'd0;
  localparam logic [2:0] IPI_CALL    = 3'd1;
  localparam logic [2:0] IPI_STOP    = 3'd3;

  typedef enum logic [1:0] {
    RUN_OFFLINE,
    RUN_ONLINE,
    RUN_DEAD,
    RUN_DYING
  } run_state_e;

  run_state_e run_q [CPU_COUNT];
  logic       done_q;
  status_e    status_q;
  logic       got_q;
  logic [2:0] src_q;
  logic [2:0] type_q;
  logic [31:0] data_q;
  logic       known_q;
  run_state_e state_q;
  logic [5:0] level_q;

  logic [CpuW-1:0]      idx;
  logic [2:0]           rd_src;
  logic [2:0]           rd_type;
  logic [StoreBits-1:0] rd_data;
  logic                 stop_taken;
  logic                 known;
  run_state_e           state_now;

  always_comb begin
    idx        = CpuW'(stage_i.cpu);
    rd_src     = rdata_i[StoreBits+3 +: 3];
    rd_type    = rdata_i[StoreBits +: 3];
    rd_data    = rdata_i[StoreBits-1:0];
    stop_taken = stage_i.valid && stage_i.got && (rd_type == IPI_STOP);
    known      = stage_i.got &&
                 ((rd_type == IPI_RESCHED) || (rd_type == IPI_CALL) || (rd_type == IPI_STOP));
    if (stage_i.status == ST_BAD_CPU) begin
      state_now = RUN_OFFLINE;
    end else if (stop_taken) begin
      state_now = RUN_DYING;
    end else begin
      state_now = run_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      for (int i = 0; i < CPU_COUNT; i++) begin
        run_q[i] <= RUN_ONLINE;
      end
    end else begin
      done_q <= stage_i.valid;
      if (stop_taken) begin
        run_q[idx] <= RUN_DYING;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.valid) begin
      status_q <= stage_i.status;
      got_q    <= stage_i.got;
      src_q    <= stage_i.got ? rd_src : 3'd0;
      type_q   <= stage_i.got ? rd_type : 3'd0;
      data_q   <= stage_i.got ? 32'(rd_data) : 32'd0;
      known_q  <= known;
      state_q  <= state_now;
      level_q  <= stage_i.level;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign got_message_o   = got_q;
  assign out_src_cpu_o   = src_q;
  assign out_msg_type_o  = type_q;
  assign out_payload_o   = data_q;
  assign type_known_o    = known_q;
  assign cpu_state_now_o = state_q;
  assign queue_level_o   = level_q;

endmodule

`default_nettype wire

>>> sv/ipi_message_queues.sv
// Inter-processor interrupt mailbox with one message queue per CPU.
// Requests arrive on a command channel: a request transfer happens at a rising
// edge with start_i high and busy_o low. A send appends the source CPU, the IPI
// type and the payload word to the target CPU's queue; a take pops the oldest
// message of that queue and returns it, flagging whether its type is handled.
// Taking a stop message marks the CPU as dying until the next reset.
// Each request gives exactly one result, shown on the result ports for one cycle
// with done_o high. busy_o is never raised, so one request is taken in every
// cycle: pointer and fill bookkeeping and the store access happen at the
// transfer edge, and the read data is used in the next cycle. The receiver cannot
// stall; a result not taken in its done_o cycle is gone. The active CPU count is
// written over its own valid/ready channel, by the user only while no request is
// in flight; the block does not enforce it. Reset empties every queue, marks
// every CPU online and sets the active CPU count to eight; the message store
// itself is not cleared, as an entry is only ever read after it has been written.
`default_nettype none

module ipi_message_queues import ipimq_pkg::*; #(
  parameter int unsigned CPU_COUNT    = NumCpusDef,
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request channel
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        req_type_i,
  input  wire logic [2:0]  src_cpu_i,
  input  wire logic [2:0]  target_cpu_i,
  input  wire logic [2:0]  msg_type_i,
  input  wire logic [31:0] payload_i,
  // Configuration channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_active_cpus_i,
  // Result channel
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic             got_message_o,
  output logic [2:0]       out_src_cpu_o,
  output logic [2:0]       out_msg_type_o,
  output logic [31:0]      out_payload_o,
  output logic             type_known_o,
  output logic [1:0]       cpu_state_now_o,
  output logic [5:0]       queue_level_o
);

  localparam int unsigned StoreDepth = CPU_COUNT * QUEUE_DEPTH;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned StoreBits  = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam int unsigned EntryW     = 6 + StoreBits;

  logic [3:0]        active_cpus_q;
  logic              accept;
  logic              mem_en;
  logic              mem_we;
  logic [AddrW-1:0]  mem_addr;
  logic [EntryW-1:0] mem_wdata;
  logic [EntryW-1:0] mem_rdata;
  stage_t            stage;

  // Every cycle can take a request; the register write channel is always open.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_cpus_q <= ActiveCpusRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_cpus_q <= cfg_active_cpus_i;
    end
  end

  // Queue bookkeeping: checks the target, moves pointers and levels, and
  // drives the store's single port in the transfer cycle.
  ipimq_queue_ctrl #(
    .CPU_COUNT    (CPU_COUNT),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_queue_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .req_type_i    (req_type_i),
    .src_cpu_i     (src_cpu_i),
    .target_cpu_i  (target_cpu_i),
    .msg_type_i    (msg_type_i),
    .payload_i     (payload_i),
    .active_cpus_i (active_cpus_q),
    .mem_en_o      (mem_en),
    .mem_we_o      (mem_we),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .stage_o       (stage)
  );

  // All queues share one store, each CPU owning a contiguous slice of it.
  ipimq_msg_ram #(
    .Depth (StoreDepth),
    .Width (EntryW)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // The result stage owns the CPU run states, so a stop message taken by one
  // request is already visible to the request right behind it.
  ipimq_result #(
    .CPU_COUNT    (CPU_COUNT),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_result (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stage_i         (stage),
    .rdata_i         (mem_rdata),
    .done_o          (done_o),
    .status_o        (status_o),
    .got_message_o   (got_message_o),
    .out_src_cpu_o   (out_src_cpu_o),
    .out_msg_type_o  (out_msg_type_o),
    .out_payload_o   (out_payload_o),
    .type_known_o    (type_known_o),
    .cpu_state_now_o (cpu_state_now_o),
    .queue_level_o   (queue_level_o)
  );

endmodule

`default_nettype wire

>>> sv/ipimq_checker.sv
`default_nettype none
`include "ipi_message_queues_macros.svh"

module ipimq_sva_checker import ipimq_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [1:0]  status_o,
  input wire logic        got_message_o,
  input wire logic        type_known_o,
  input wire logic [1:0]  cpu_state_now_o,
  input wire logic [5:0]  queue_level_o
);

  localparam logic [1:0] RUN_OFFLINE = 2'd0;

  logic req_xfer;
  logic msg_flag;
  logic ok_take;
  logic bad_result;
  logic bad_quiet;

  assign req_xfer   = start_i && !busy_o;
  assign msg_flag   = got_message_o || type_known_o;
  assign ok_take    = got_message_o && (status_o == ST_OK);
  assign bad_result = done_o && (status_o == ST_BAD_CPU);
  assign bad_quiet  = (cpu_state_now_o == RUN_OFFLINE) && (queue_level_o == 6'd0) &&
                      !got_message_o;

  // Each request transfer yields its result through the stage and result registers.
  `IPIMQ_ASSERT(a_result_follows, req_xfer |-> ##2 done_o, "result missing")

  // No result without an earlier request transfer.
  `IPIMQ_ASSERT(a_no_spurious, done_o |-> $past(req_xfer, 2), "spurious result")

  // A returned message is always a successful take with a known or unknown type.
  `IPIMQ_ASSERT(a_got_ok, (done_o && msg_flag) |-> ok_take, "message on failed take")

  // A rejected target reports the offline state, a zero level and no message.
  `IPIMQ_ASSERT(a_bad_cpu_zero, bad_result |-> bad_quiet, "invalid target shows state")

  // Reset flushes the pipeline.
  `IPIMQ_ASSERT_RST(a_reset_flush, !rst_ni |=> !done_o, "result after reset")

endmodule

bind ipi_message_queues ipimq_sva_checker u_checker (.*);

`default_nettype wire

>>> bench/ipimq_checker.sv
package ipimq_bench_pkg;

  // Request kind carried on req_type.
  typedef enum logic {
    REQ_SEND,
    REQ_TAKE
  } req_e;

  // IPI message types; the last code has no meaning but is stored as given.
  typedef enum logic [2:0] {
    IPI_RESCHED,
    IPI_CALL,
    IPI_CALL_SINGLE,
    IPI_STOP,
    IPI_TICK,
    IPI_DEFER_WORK,
    IPI_WAKE,
    IPI_RESERVED
  } ipi_e;

endpackage

module ipimq_checker
  import ipimq_pkg::*;
  import ipimq_bench_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic        req_type_i,
  input  wire logic [2:0]  src_cpu_i,
  input  wire logic [2:0]  target_cpu_i,
  input  wire logic [2:0]  msg_type_i,
  input  wire logic [31:0] payload_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [3:0]  cfg_active_cpus_i,
  input  wire logic        done_i,
  input  wire logic [1:0]  status_i,
  input  wire logic        got_message_i,
  input  wire logic [2:0]  out_src_cpu_i,
  input  wire logic [2:0]  out_msg_type_i,
  input  wire logic [31:0] out_payload_i,
  input  wire logic        type_known_i,
  input  wire logic [1:0]  cpu_state_now_i,
  input  wire logic [5:0]  queue_level_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_o,
  output int               delivered_o,
  output int               refused_full_o
);

  localparam int unsigned CPUS  = NumCpusDef;
  localparam int unsigned DEPTH = QueueDepthDef;

  typedef enum logic [1:0] {
    RS_OFFLINE,
    RS_ONLINE,
    RS_DEAD,
    RS_DYING
  } run_e;

  typedef struct packed {
    logic [2:0]  src;
    ipi_e        kind;
    logic [31:0] data;
  } mailbox_entry_t;

  typedef struct packed {
    status_e     status;
    logic        got;
    logic [2:0]  src;
    ipi_e        kind;
    logic [31:0] data;
    logic        known;
    run_e        state;
    logic [5:0]  level;
  } mailbox_result_t;

  // Shadow of the mailbox state.
  mailbox_entry_t msg_store [CPUS][DEPTH];
  int unsigned    rd_slot   [CPUS];
  int unsigned    wr_slot   [CPUS];
  int unsigned    fill      [CPUS];
  run_e           run_state [CPUS];
  logic [3:0]     active_cpus;

  mailbox_result_t expected_results [$];
  int errors, results, delivered, refused_full;

  initial begin
    errors       = 0;
    results      = 0;
    delivered    = 0;
    refused_full = 0;
  end

  task automatic report_mismatch(string text);
    errors++;
    $display("[%0t] mismatch: %s", $time, text);
  endtask

  task automatic check_field(string name, logic [31:0] seen, logic [31:0] want);
    if (seen !== want) begin
      report_mismatch($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                                results, name, seen, want));
    end
  endtask

  // Applies one request to the shadow state and returns the result it must give.
  function automatic mailbox_result_t predict_mailbox(req_e req, logic [2:0] src,
                                                      logic [2:0] cpu, ipi_e kind,
                                                      logic [31:0] data);
    mailbox_result_t r;
    mailbox_entry_t  head;
    int unsigned     limit;
    r     = '0;
    limit = (active_cpus < CPUS) ? active_cpus : CPUS;
    if (cpu >= limit) begin
      r.status = ST_BAD_CPU;
      return r;
    end
    if (req == REQ_SEND) begin
      if (fill[cpu] >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        msg_store[cpu][wr_slot[cpu]] = '{src: src, kind: kind, data: data};
        wr_slot[cpu] = (wr_slot[cpu] == DEPTH - 1) ? 0 : wr_slot[cpu] + 1;
        fill[cpu]++;
        r.status = ST_OK;
      end
    end else if (fill[cpu] == 0) begin
      r.status = ST_EMPTY;
    end else begin
      head = msg_store[cpu][rd_slot[cpu]];
      rd_slot[cpu] = (rd_slot[cpu] == DEPTH - 1) ? 0 : rd_slot[cpu] + 1;
      fill[cpu]--;
      r.status = ST_OK;
      r.got    = 1'b1;
      r.src    = head.src;
      r.kind   = head.kind;
      r.data   = head.data;
      r.known  = (head.kind == IPI_RESCHED) || (head.kind == IPI_CALL) ||
                 (head.kind == IPI_STOP);
      if (head.kind == IPI_STOP) begin
        run_state[cpu] = RS_DYING;
      end
    end
    r.state = run_state[cpu];
    r.level = fill[cpu][5:0];
    return r;
  endfunction

  // Results are compared before the request of the same edge is predicted;
  // the two never concern the same request, as each result trails its transfer.
  always @(posedge clk_i) begin
    mailbox_result_t want;
    if (!rst_ni) begin
      for (int c = 0; c < CPUS; c++) begin
        rd_slot[c]   = 0;
        wr_slot[c]   = 0;
        fill[c]      = 0;
        run_state[c] = RS_ONLINE;
      end
      active_cpus = ActiveCpusRst;
      expected_results.delete();
    end else begin
      if (done_i === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    results));
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(status_i), 32'(want.status));
          check_field("got_message", 32'(got_message_i), 32'(want.got));
          check_field("out_src_cpu", 32'(out_src_cpu_i), 32'(want.src));
          check_field("out_msg_type", 32'(out_msg_type_i), 32'(want.kind));
          check_field("out_payload", out_payload_i, want.data);
          check_field("type_known", 32'(type_known_i), 32'(want.known));
          check_field("cpu_state_now", 32'(cpu_state_now_i), 32'(want.state));
          check_field("queue_level", 32'(queue_level_i), 32'(want.level));
          if (want.got) delivered++;
          if (want.status == ST_FULL) refused_full++;
        end
        results++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        active_cpus = cfg_active_cpus_i;
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(predict_mailbox(req_e'(req_type_i), src_cpu_i,
                                                   target_cpu_i, ipi_e'(msg_type_i),
                                                   payload_i));
      end
    end
    fail_count_o   <= errors;
    pending_o      <= expected_results.size();
    results_o      <= results;
    delivered_o    <= delivered;
    refused_full_o <= refused_full;
  end

endmodule

>>> bench/tb.sv
// Testbench top for the IPI mailbox. It only generates stimulus and gives the
// verdict; prediction and comparison live in the checker instantiated beside
// the block, which hands back a failure count and the number of results still
// outstanding.
module tb;
  import ipimq_pkg::*;
  import ipimq_bench_pkg::*;

  localparam int RESULT_LATENCY = 2;
  // Cycles without any transfer on any channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PERCENT   = 34;

  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED
  } burst_e;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic        req_type        = 1'b0;
  logic [2:0]  src_cpu         = '0;
  logic [2:0]  target_cpu      = '0;
  logic [2:0]  msg_type        = '0;
  logic [31:0] payload         = '0;
  logic        cfg_valid       = 1'b0;
  logic [3:0]  cfg_active_cpus = ActiveCpusRst;

  logic        busy, cfg_ready, done;
  logic [1:0]  status;
  logic        got_message;
  logic [2:0]  out_src_cpu, out_msg_type;
  logic [31:0] out_payload;
  logic        type_known;
  logic [1:0]  cpu_state_now;
  logic [5:0]  queue_level;

  int fail_count, pending, results, delivered, refused_full;

  // Bookkeeping for stimulus and the closing summary.
  logic        idling      = 1'b1;
  int unsigned cur_active  = ActiveCpusRst;
  int unsigned n_sends     = 0;
  int unsigned n_takes     = 0;
  int unsigned n_settings  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned phase_cfg [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ipi_message_queues DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_o            (busy),
    .req_type_i        (req_type),
    .src_cpu_i         (src_cpu),
    .target_cpu_i      (target_cpu),
    .msg_type_i        (msg_type),
    .payload_i         (payload),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_active_cpus_i (cfg_active_cpus),
    .done_o            (done),
    .status_o          (status),
    .got_message_o     (got_message),
    .out_src_cpu_o     (out_src_cpu),
    .out_msg_type_o    (out_msg_type),
    .out_payload_o     (out_payload),
    .type_known_o      (type_known),
    .cpu_state_now_o   (cpu_state_now),
    .queue_level_o     (queue_level)
  );

  ipimq_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_i            (busy),
    .req_type_i        (req_type),
    .src_cpu_i         (src_cpu),
    .target_cpu_i      (target_cpu),
    .msg_type_i        (msg_type),
    .payload_i         (payload),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_active_cpus_i (cfg_active_cpus),
    .done_i            (done),
    .status_i          (status),
    .got_message_i     (got_message),
    .out_src_cpu_i     (out_src_cpu),
    .out_msg_type_i    (out_msg_type),
    .out_payload_i     (out_payload),
    .type_known_i      (type_known),
    .cpu_state_now_i   (cpu_state_now),
    .queue_level_i     (queue_level),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .results_o         (results),
    .delivered_o       (delivered),
    .refused_full_o    (refused_full)
  );

  // Presents one request and waits for its transfer. With idling enabled each
  // cycle before it may be left empty at random. After the transfer start is
  // left high, so that back-to-back requests never lower and raise it within
  // one step; whoever comes next decides whether it falls.
  task automatic issue(req_e req, logic [2:0] src, logic [2:0] cpu, ipi_e kind,
                       logic [31:0] data);
    while (idling && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    req_type   <= req;
    src_cpu    <= src;
    target_cpu <= cpu;
    msg_type   <= kind;
    payload    <= data;
    do @(posedge clk); while (busy);
    if (req == REQ_SEND) n_sends++;
    else n_takes++;
  endtask

  // Stops issuing and waits until every expected result has been seen, plus a
  // short margin. The first edge lets the checker's count catch up with a
  // transfer that happened at the edge we are standing on.
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // Writes the active CPU count while the mailbox is idle.
  task automatic set_active_cpus(logic [3:0] value);
    wait_quiet();
    cfg_valid       <= 1'b1;
    cfg_active_cpus <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cur_active = value;
    n_settings++;
  endtask

  // Mostly a CPU that is currently valid, now and then any CPU at all.
  function automatic logic [2:0] pick_target();
    int unsigned limit;
    limit = (cur_active < NumCpusDef) ? cur_active : NumCpusDef;
    if (limit == 0 || $urandom_range(0, 99) < 10) begin
      return 3'($urandom_range(0, 7));
    end
    return 3'($urandom_range(0, limit - 1));
  endfunction

  // Random traffic in bursts. Fill bursts hammer one queue mostly with sends so
  // that it can overflow, drain bursts mostly take from it to reach the empty
  // case, and mixed bursts scatter sends and takes over all CPUs.
  task automatic run_phase(int unsigned items);
    int unsigned issued;
    int unsigned burst;
    burst_e      kind;
    req_e        req;
    logic [2:0]  cpu;
    issued = 0;
    while (issued < items) begin
      kind  = burst_e'($urandom_range(0, 2));
      burst = $urandom_range(8, 40);
      if (burst > items - issued) begin
        burst = items - issued;
      end
      cpu   = pick_target();
      for (int unsigned k = 0; k < burst; k++) begin
        case (kind)
          BURST_FILL: begin
            req = ($urandom_range(0, 99) < 85) ? REQ_SEND : REQ_TAKE;
          end
          BURST_DRAIN: begin
            req = ($urandom_range(0, 99) < 85) ? REQ_TAKE : REQ_SEND;
          end
          default: begin
            req = req_e'($urandom_range(0, 1));
            cpu = pick_target();
          end
        endcase
        issue(req, 3'($urandom_range(0, 7)), cpu, ipi_e'($urandom_range(0, 7)),
              $urandom);
      end
      issued += burst;
    end
  endtask

  initial begin
    logic [31:0] data;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A take from an empty queue first, then one message of
    // every type into the highest CPU, with the payload extremes among them.
    issue(REQ_TAKE, 3'd0, 3'd0, IPI_RESCHED, 32'h0);
    for (int i = 0; i < 8; i++) begin
      case (i)
        0:       data = 32'h0000_0000;
        1:       data = 32'hFFFF_FFFF;
        2:       data = 32'hA5A5_A5A5;
        3:       data = 32'h5A5A_5A5A;
        default: data = $urandom;
      endcase
      issue(REQ_SEND, 3'(7 - i), 3'd7, ipi_e'(i), data);
    end
    // Taking them back returns every type in order; the stop message turns
    // the CPU dying, and the takes after it still work.
    for (int i = 0; i < 8; i++) begin
      issue(REQ_TAKE, 3'($urandom), 3'd7, ipi_e'($urandom), $urandom);
    end
    // A dying CPU keeps accepting and handing out messages.
    issue(REQ_SEND, 3'd0, 3'd7, IPI_CALL, 32'h8000_0001);
    issue(REQ_TAKE, 3'd0, 3'd7, IPI_RESCHED, 32'h0);

    // No active CPUs: every target is invalid.
    set_active_cpus(4'd0);
    issue(REQ_SEND, 3'd1, 3'd0, IPI_TICK, 32'h1234_5678);
    issue(REQ_TAKE, 3'd1, 3'd0, IPI_RESCHED, 32'h0);
    // A count above the number of CPUs behaves as all of them.
    set_active_cpus(4'd15);
    issue(REQ_SEND, 3'd2, 3'd7, IPI_WAKE, 32'hDEAD_BEEF);
    issue(REQ_TAKE, 3'd2, 3'd7, IPI_RESCHED, 32'h0);
    // Boundary of a partial count: CPU 3 is out, CPU 2 is in.
    set_active_cpus(4'd3);
    issue(REQ_SEND, 3'd4, 3'd3, IPI_DEFER_WORK, 32'h0F0F_0F0F);
    issue(REQ_SEND, 3'd4, 3'd2, IPI_CALL_SINGLE, 32'hF0F0_F0F0);

    // Random part over several settings, the extremes among them. The fourth
    // phase runs without any idling so that requests arrive every cycle.
    phase_cfg = '{8, 1, 15, 4, 0, 6, 2, 8};
    for (int p = 0; p < 8; p++) begin
      set_active_cpus(4'(phase_cfg[p]));
      idling = (p != 3);
      run_phase((phase_cfg[p] == 0) ? 24 : 160);
    end

    wait_quiet();
    $display("Summary: %0d requests (%0d sends, %0d takes) over %0d CPU-count settings,",
             n_sends + n_takes, n_sends, n_takes, n_settings);
    $display("  %0d results checked, %0d messages delivered, %0d sends refused as full.",
             results, delivered, refused_full);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transfer", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> ipi_message_queues.f
+incdir+sv
sv/ipimq_pkg.sv
sv/ipimq_msg_ram.sv
sv/ipimq_queue_ctrl.sv
sv/ipimq_result.sv
sv/ipi_message_queues.sv
sv/ipimq_checker.sv
bench/ipimq_checker.sv
bench/tb.sv
